/* rtl/tlbs_pkg.sv */
// tlbs_pkg: shared types, constants and unit classification helpers
// for the text line break scanner. No dependencies.

package tlbs_pkg;

	localparam int LENGTH_BITS = 20;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_TAB = 8'h09;

	localparam logic RESULT_LINE    = 1'b0;
	localparam logic RESULT_SUMMARY = 1'b1;

	localparam int REC_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	typedef enum logic [2:0] {
		REG_UNIT_SIZE   = 3'd0,
		REG_BIG_ENDIAN  = 3'd1,
		REG_SKIP_MASK   = 3'd2,
		REG_SKIP_VALUE  = 3'd3,
		REG_START_LINE  = 3'd4,
		REG_START_MAX   = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_COUNT,
		EV_TAB,
		EV_BREAK
	} ev_kind_t;

	typedef enum logic [1:0] {
		STEP_EV0,
		STEP_EV1,
		STEP_SUM
	} sub_step_t;

	typedef struct packed {
		logic [31:0] code_unit;
		logic        last_unit;
	} in_item_t;

	typedef struct packed {
		logic                   result_kind;
		logic [31:0]            line_start_offset;
		logic [LENGTH_BITS-1:0] line_length;
		logic [LENGTH_BITS-1:0] longest_line;
		logic                   last_result;
	} out_item_t;

	typedef struct packed {
		logic        we;
		logic [2:0]  idx;
		logic [31:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [1:0]  unit_size;
		logic        big_endian;
		logic [31:0] skip_mask;
		logic [31:0] skip_value;
	} scan_cfg_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [31:0] offset;
	} unit_ev_t;

	// one record per accepted transaction: held unit event, flush event, summary
	typedef struct packed {
		unit_ev_t ev0;
		unit_ev_t ev1;
		logic     summary;
	} scan_rec_t;

	function automatic logic [1:0] size_shift(logic [1:0] us);
		logic [1:0] s;
		unique case (us)
			2'd0: s = 2'd0;
			2'd1: s = 2'd1;
			default: s = 2'd2;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] unit_mask(logic [1:0] us);
		logic [31:0] m;
		unique case (size_shift(us))
			2'd0: m = 32'h0000_00ff;
			2'd1: m = 32'h0000_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] code_of(logic [7:0] c, scan_cfg_t cfg);
		logic [1:0]  s;
		logic [31:0] r;
		s = size_shift(cfg.unit_size);
		if (!cfg.big_endian || s == 2'd0) begin
			r = {24'b0, c};
		end else if (s == 2'd1) begin
			r = {16'b0, c, 8'b0};
		end else begin
			r = {c, 24'b0};
		end
		return r;
	endfunction

	// u is already cut to the unit width
	function automatic ev_kind_t classify(logic [31:0] u, scan_cfg_t cfg);
		logic [31:0] um;
		logic [31:0] m;
		logic [31:0] v;
		ev_kind_t    k;
		um = unit_mask(cfg.unit_size);
		m  = cfg.skip_mask & um;
		v  = cfg.skip_value & um;
		if (u == code_of(CH_CR, cfg) || u == code_of(CH_LF, cfg)) begin
			k = EV_BREAK;
		end else if (u == code_of(CH_TAB, cfg)) begin
			k = EV_TAB;
		end else if (m != 32'd0 && (u & m) == v) begin
			k = EV_NONE;
		end else begin
			k = EV_COUNT;
		end
		return k;
	endfunction

	function automatic logic is_pair(logic [31:0] a, logic [31:0] b, scan_cfg_t cfg);
		logic [31:0] cr;
		logic [31:0] lf;
		cr = code_of(CH_CR, cfg);
		lf = code_of(CH_LF, cfg);
		return (a == cr && b == lf) || (a == lf && b == cr);
	endfunction

endpackage

/* rtl/tlbs_front.sv */
// tlbs_front: accepts code units, holds one unit of lookahead, classifies
// units and builds one event record per transaction. Uses tlbs_pkg.

module tlbs_front
	import tlbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_wr_t   cfg_wr,
	input  logic      accept,
	input  in_item_t  item,
	output scan_rec_t rec
);

	scan_cfg_t   cfg_q;
	logic [31:0] held_q;
	logic        held_valid_q;
	logic [31:0] pos_q;

	logic [31:0] um;
	logic [1:0]  sh;
	logic [31:0] u;
	logic [31:0] h;
	logic [31:0] off1;
	logic [31:0] off2;
	logic        pair;
	logic [31:0] held_n;
	logic        hv_n;
	logic [31:0] pos_n;

	always_comb begin
		um   = unit_mask(cfg_q.unit_size);
		sh   = size_shift(cfg_q.unit_size);
		u    = item.code_unit & um;
		h    = held_q & um;
		off1 = (pos_q + 32'd1) << sh;
		off2 = (pos_q + 32'd2) << sh;
		pair = is_pair(h, u, cfg_q);

		rec.ev0.kind   = EV_NONE;
		rec.ev0.offset = '0;
		rec.ev1.kind   = EV_NONE;
		rec.ev1.offset = '0;
		rec.summary    = item.last_unit;

		held_n = held_q;
		hv_n   = held_valid_q;
		pos_n  = pos_q;

		if (held_valid_q) begin
			if (pair) begin
				rec.ev0.kind   = EV_BREAK;
				rec.ev0.offset = off2;
				pos_n          = pos_q + 32'd2;
				hv_n           = 1'b0;
			end else begin
				rec.ev0.kind   = classify(h, cfg_q);
				rec.ev0.offset = off1;
				pos_n          = pos_q + 32'd1;
				held_n         = u;
				hv_n           = 1'b1;
			end
		end else begin
			held_n = u;
			hv_n   = 1'b1;
		end

		// end of buffer: flush the unit just taken, if still held
		if (item.last_unit) begin
			if (hv_n) begin
				rec.ev1.kind   = classify(u, cfg_q);
				rec.ev1.offset = held_valid_q ? off2 : off1;
			end
			pos_n  = '0;
			held_n = '0;
			hv_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q        <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			pos_q        <= '0;
		end else begin
			if (cfg_wr.we) begin
				unique case (cfg_reg_t'(cfg_wr.idx))
					REG_UNIT_SIZE:  cfg_q.unit_size  <= cfg_wr.data[1:0];
					REG_BIG_ENDIAN: cfg_q.big_endian <= cfg_wr.data[0];
					REG_SKIP_MASK:  cfg_q.skip_mask  <= cfg_wr.data;
					REG_SKIP_VALUE: cfg_q.skip_value <= cfg_wr.data;
					default: ;
				endcase
			end
			if (accept) begin
				held_q       <= held_n;
				held_valid_q <= hv_n;
				pos_q        <= pos_n;
			end
		end
	end

endmodule

/* rtl/tlbs_rec_queue.sv */
// tlbs_rec_queue: short record queue between front and back ends.
// Uses tlbs_pkg.

module tlbs_rec_queue
	import tlbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  scan_rec_t wdata,
	output logic      full,
	input  logic      rd,
	output scan_rec_t rdata,
	output logic      empty
);

	localparam int PW = $clog2(REC_DEPTH);

	scan_rec_t       mem_q [REC_DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [PW:0]     cnt_q;

	assign full  = (cnt_q == (PW+1)'(REC_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end

endmodule

/* rtl/tlbs_back.sv */
// tlbs_back: walks event records, keeps line length and longest line,
// and queues result transactions. Uses tlbs_pkg.

module tlbs_back
	import tlbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_wr_t   cfg_wr,
	input  scan_rec_t rec,
	input  logic      rec_valid,
	output logic      rec_pop,
	output out_item_t result,
	output logic      empty,
	input  logic      pop
);

	localparam int PW = $clog2(RES_DEPTH);

	sub_step_t              step_q;
	sub_step_t              step_n;
	logic [LENGTH_BITS-1:0] open_q;
	logic [LENGTH_BITS-1:0] longest_q;
	logic [LENGTH_BITS-1:0] open_n;
	logic [LENGTH_BITS-1:0] longest_n;

	out_item_t              res_mem_q [RES_DEPTH];
	logic [PW-1:0]          res_wptr_q;
	logic [PW-1:0]          res_rptr_q;
	logic [PW:0]            res_cnt_q;

	unit_ev_t               ev;
	logic                   emits;
	logic                   room;
	logic                   go;
	logic                   final_step;
	logic                   res_push;
	logic                   res_pop;
	out_item_t              res_new;
	logic [LENGTH_BITS:0]   tab_len;

	assign room    = (res_cnt_q != (PW+1)'(RES_DEPTH));
	assign empty   = (res_cnt_q == '0);
	assign result  = res_mem_q[res_rptr_q];
	assign res_pop = pop && !empty;

	// next multiple of four, one bit of headroom for saturation
	assign tab_len = {({1'b0, open_q[LENGTH_BITS-1:2]} + (LENGTH_BITS-1)'(1)), 2'b00};

	always_comb begin
		ev.kind   = EV_NONE;
		ev.offset = '0;
		emits     = 1'b0;
		unique case (step_q)
			STEP_EV0: begin
				ev    = rec.ev0;
				emits = (rec.ev0.kind == EV_BREAK);
			end
			STEP_EV1: begin
				ev    = rec.ev1;
				emits = (rec.ev1.kind == EV_BREAK);
			end
			default: emits = 1'b1;
		endcase

		go         = rec_valid && (!emits || room);
		final_step = !rec.summary || step_q == STEP_SUM;
		rec_pop    = go && final_step;

		step_n = step_q;
		if (go) begin
			if (final_step) begin
				step_n = STEP_EV0;
			end else if (step_q == STEP_EV0) begin
				step_n = STEP_EV1;
			end else begin
				step_n = STEP_SUM;
			end
		end

		open_n    = open_q;
		longest_n = longest_q;
		res_new.result_kind       = RESULT_LINE;
		res_new.line_start_offset = ev.offset;
		res_new.line_length       = '0;
		res_new.longest_line      = longest_q;
		res_new.last_result       = !rec.summary;

		if (step_q == STEP_SUM) begin
			res_new.result_kind       = RESULT_SUMMARY;
			res_new.line_start_offset = '0;
			res_new.line_length       = open_q;
			res_new.last_result       = 1'b1;
		end else begin
			unique case (ev.kind)
				EV_BREAK: begin
					if (open_q > longest_q) begin
						longest_n = open_q;
					end
					open_n = '0;
					res_new.longest_line = longest_n;
				end
				EV_TAB: open_n = tab_len[LENGTH_BITS] ? LEN_MAX : tab_len[LENGTH_BITS-1:0];
				EV_COUNT: begin
					if (open_q != LEN_MAX) begin
						open_n = open_q + LENGTH_BITS'(1);
					end
				end
				default: ;
			endcase
		end

		res_push = go && emits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_EV0;
		end else begin
			step_q <= step_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= '0;
			longest_q <= '0;
		end else if (cfg_wr.we && cfg_reg_t'(cfg_wr.idx) == REG_START_LINE) begin
			open_q <= cfg_wr.data[LENGTH_BITS-1:0];
		end else if (cfg_wr.we && cfg_reg_t'(cfg_wr.idx) == REG_START_MAX) begin
			longest_q <= cfg_wr.data[LENGTH_BITS-1:0];
		end else if (go) begin
			open_q    <= open_n;
			longest_q <= longest_n;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[res_wptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wptr_q <= '0;
			res_rptr_q <= '0;
			res_cnt_q  <= '0;
		end else begin
			if (res_push) begin
				res_wptr_q <= res_wptr_q + PW'(1);
			end
			if (res_pop) begin
				res_rptr_q <= res_rptr_q + PW'(1);
			end
			res_cnt_q <= res_cnt_q + (PW+1)'(res_push) - (PW+1)'(res_pop);
		end
	end

endmodule

/* rtl/text_line_break_scanner.sv */
// text_line_break_scanner: top level; front end, record queue, back end.
// Uses tlbs_pkg, tlbs_front, tlbs_rec_queue, tlbs_back.
//
//   channel   handshake            payload
//   item      push / full          in_item_t  {code_unit, last_unit}
//   result    empty / pop          out_item_t {result_kind .. last_result}
//   config    cfg_we               cfg_index (3b), cfg_data (32b)
//
// A unit without last_unit needs only the held-unit step; one per cycle unless stalled.
// A unit with last_unit takes the back-end steps held unit, flush and summary in turn.
// The back end emits at most one result per cycle into a 4-entry result queue.
// A result passes through the record queue and then the result queue to the ports.
// Reset clears all control state at once; no clearing pass.
// A full result queue stalls emitting back-end steps; a full record queue raises full.

module text_line_break_scanner
	import tlbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_wr_t   cfg_wr;
	scan_rec_t rec_in;
	scan_rec_t rec_out;
	logic      accept;
	logic      rec_empty;
	logic      rec_pop;

	assign cfg_wr.we   = cfg_we;
	assign cfg_wr.idx  = cfg_index;
	assign cfg_wr.data = cfg_data;
	assign accept      = push && !full;

	tlbs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.accept (accept),
		.item   (item),
		.rec    (rec_in)
	);

	tlbs_rec_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wdata  (rec_in),
		.full   (full),
		.rd     (rec_pop),
		.rdata  (rec_out),
		.empty  (rec_empty)
	);

	tlbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.rec       (rec_out),
		.rec_valid (!rec_empty),
		.rec_pop   (rec_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

/* rtl/tlbs_checker.sv */
// tlbs_checker: port-level checks for text_line_break_scanner, bound to it.
// Uses tlbs_pkg.

module tlbs_checker
	import tlbs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input out_item_t   result
);

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("queues not empty during reset");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.result_kind == RESULT_SUMMARY) |-> result.last_result)
		else $error("summary transaction not marked last");

	a_break_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.result_kind == RESULT_LINE) |-> result.line_length == '0)
		else $error("line start transaction with nonzero length");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while stalled");

endmodule

bind text_line_break_scanner tlbs_checker u_tlbs_checker (.*);
